[rtl/vld_pkg.sv]
// ----------------------------------------------------------------------------
// vld_pkg : shared types and constants for the vector length/direction block
// Widths derived from the coordinate width, Q16 tangent thresholds and the
// structs carried between the pipeline sections.
// ----------------------------------------------------------------------------
package vld_pkg;

  // Coordinate width of each input field
  localparam int COORD_W = 16;
  // Difference of two coordinates, signed
  localparam int DIFF_W  = COORD_W + 1;
  // Magnitude of a difference
  localparam int MAG_W   = COORD_W;
  // Square of a magnitude and sum of two squares
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;
  // Integer length (square root of the sum)
  localparam int LEN_W   = COORD_W + 1;
  // Remainder width in the digit-by-digit square root
  localparam int REM_W   = 2 * LEN_W;
  // Q16 tangent thresholds and their products with a magnitude
  localparam int FRAC_W  = 16;
  localparam int TAN_W   = 19;
  localparam int TAN_N   = 4;
  localparam int NUM_W   = MAG_W + FRAC_W;
  localparam int PROD_W  = TAN_W + MAG_W;

  // tan of 11.25, 33.75, 56.25 and 78.75 degrees, rounded, Q16
  localparam logic [TAN_N-1:0][TAN_W-1:0] TAN_Q16 = {
    19'd329472, 19'd98082, 19'd43790, 19'd13036
  };

  // Sector codes of the axis directions
  localparam logic [3:0] DIR_EAST  = 4'd0;
  localparam logic [3:0] DIR_NORTH = 4'd4;
  localparam logic [3:0] DIR_WEST  = 4'd8;
  localparam logic [3:0] DIR_SOUTH = 4'd12;
  localparam logic [3:0] DIR_HALF  = 4'd8;

  // Signs and zero flags of the two deltas
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } vld_quad_t;

  // Squares and threshold products, output of the front section
  typedef struct packed {
    logic [SQ_W-1:0]                sq_x;
    logic [SQ_W-1:0]                sq_y;
    logic [TAN_N-1:0][PROD_W-1:0]   prod;
    logic [MAG_W-1:0]               ay;
    vld_quad_t                      quad;
  } vld_prod_t;

  // Result fields that travel beside the square root
  typedef struct packed {
    logic [3:0] dir;
    logic       pt;
  } vld_side_t;

  // Sum of squares plus side fields, output of the combine stage
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    vld_side_t        side;
  } vld_sum_t;

endpackage

[rtl/vector_length_and_direction_16_top.sv]
// ----------------------------------------------------------------------------
// vector_length_and_direction_16_top : vector length and 16-sector direction
// Integer length of end minus start and its quantised direction code.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries one item: start and end points,
//   16-bit two's complement. Output channel out_valid/out_ready carries one
//   result item per input item: floor of the Euclidean length, the sector
//   code (0 east, 4 north, 8 west, 12 south, 22.5 degree steps) and is_point
//   for a zero-length vector (length 0, direction 0).
//   The pipeline has 20 register stages: two front stages (deltas, then
//   multiplies), one combine stage (sum of squares, sector) and 17
//   square-root stages, one result bit each. Unless the receiver stalls,
//   an item may enter every cycle, so throughput is one item per cycle.
//   Every stage carries a valid bit and loads whenever it is empty or its
//   successor takes its item, so a stalled receiver holds the last result
//   while earlier stages keep filling; in_ready drops only once all 20
//   stages hold items. Results leave in input order.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is
//   pending afterwards.
// ----------------------------------------------------------------------------
module vector_length_and_direction_16_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vld_pkg::COORD_W-1:0] in_start_x,
  input  logic [vld_pkg::COORD_W-1:0] in_start_y,
  input  logic [vld_pkg::COORD_W-1:0] in_end_x,
  input  logic [vld_pkg::COORD_W-1:0] in_end_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vld_pkg::LEN_W-1:0]   out_length,
  output logic [3:0]                  out_direction,
  output logic                        out_is_point
);
  import vld_pkg::*;

  logic       prod_valid;
  logic       prod_ready;
  vld_prod_t  prod_data;
  logic       sum_valid;
  logic       sum_ready;
  vld_sum_t   sum_data;
  vld_side_t  side;

  // Deltas and multiplies
  vld_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .m_valid (prod_valid),
    .m_ready (prod_ready),
    .m_data  (prod_data)
  );

  // Sum of squares and sector code
  vld_combine u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (prod_valid),
    .s_ready (prod_ready),
    .s_data  (prod_data),
    .m_valid (sum_valid),
    .m_ready (sum_ready),
    .m_data  (sum_data)
  );

  // Square root, side fields alongside
  vld_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sum_valid),
    .s_ready (sum_ready),
    .s_data  (sum_data),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_root  (out_length),
    .m_side  (side)
  );

  assign out_direction = side.dir;
  assign out_is_point  = side.pt;

  // A point has zero length and points east
  a_point_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_point |-> (out_length == '0) && (out_direction == DIR_EAST))
    else $error("point item with non-zero length or direction");

  // Any other vector has a length of at least one
  a_len_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_point |-> (out_length != '0))
    else $error("non-point item with zero length");

  // Input back-pressure only with a full pipeline behind a stalled output
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side is free");

endmodule

[rtl/vld_front.sv]
// ----------------------------------------------------------------------------
// vld_front : delta and multiply stages
// Stage 1 forms the deltas, their magnitudes and signs; stage 2 squares the
// magnitudes and multiplies |dx| by each tangent threshold.
// ----------------------------------------------------------------------------
module vld_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [vld_pkg::COORD_W-1:0]  start_x,
  input  logic [vld_pkg::COORD_W-1:0]  start_y,
  input  logic [vld_pkg::COORD_W-1:0]  end_x,
  input  logic [vld_pkg::COORD_W-1:0]  end_y,
  output logic                         m_valid,
  input  logic                         m_ready,
  output vld_pkg::vld_prod_t           m_data
);
  import vld_pkg::*;

  logic              v1_r;
  logic [MAG_W-1:0]  ax1_r;
  logic [MAG_W-1:0]  ay1_r;
  vld_quad_t         quad1_r;
  logic              v2_r;
  vld_prod_t         data2_r;

  logic              rdy1;
  logic              rdy2;
  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0] dx_abs;
  logic [DIFF_W-1:0] dy_abs;
  vld_quad_t         quad_nxt;
  vld_prod_t         data2_nxt;

  // Stage ready: load when empty or when the next stage takes the item
  assign rdy2    = !v2_r || m_ready;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;

  // Form the deltas with one guard bit and take their magnitudes
  always_comb begin
    dx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    dy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    dx_abs = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
    dy_abs = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
    quad_nxt.dx_zero = (dx == '0);
    quad_nxt.dy_zero = (dy == '0);
    quad_nxt.dx_neg  = dx[DIFF_W-1];
    quad_nxt.dy_neg  = dy[DIFF_W-1];
  end

  // Square the magnitudes and scale |dx| by each threshold
  always_comb begin
    data2_nxt.sq_x = SQ_W'(ax1_r) * SQ_W'(ax1_r);
    data2_nxt.sq_y = SQ_W'(ay1_r) * SQ_W'(ay1_r);
    for (int k = 0; k < TAN_N; k++) begin
      data2_nxt.prod[k] = PROD_W'(TAN_Q16[k]) * PROD_W'(ax1_r);
    end
    data2_nxt.ay   = ay1_r;
    data2_nxt.quad = quad1_r;
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= s_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  // Load the payload registers with their items
  always_ff @(posedge clk) begin
    if (rdy1 && s_valid) begin
      ax1_r   <= dx_abs[MAG_W-1:0];
      ay1_r   <= dy_abs[MAG_W-1:0];
      quad1_r <= quad_nxt;
    end
    if (rdy2 && v1_r) begin
      data2_r <= data2_nxt;
    end
  end

  assign m_valid = v2_r;
  assign m_data  = data2_r;

endmodule

[rtl/vld_combine.sv]
// ----------------------------------------------------------------------------
// vld_combine : sum of squares and sector decision
// Adds the two squares and resolves the 16-sector direction code from the
// threshold compares, the axis cases and the quadrant.
// ----------------------------------------------------------------------------
module vld_combine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  vld_pkg::vld_prod_t  s_data,
  output logic                m_valid,
  input  logic                m_ready,
  output vld_pkg::vld_sum_t   m_data
);
  import vld_pkg::*;

  logic            v_r;
  vld_sum_t        data_r;
  vld_sum_t        data_nxt;
  logic            rdy;
  logic [PROD_W-1:0] num;
  logic [2:0]      cnt_ge;
  logic [2:0]      cnt_le;
  logic [3:0]      sect;
  logic            same;

  assign rdy     = !v_r || m_ready;
  assign s_ready = rdy;

  // Count the thresholds on each side of the slope
  always_comb begin
    num    = PROD_W'({s_data.ay, {FRAC_W{1'b0}}});
    cnt_ge = '0;
    cnt_le = '0;
    for (int k = 0; k < TAN_N; k++) begin
      cnt_ge = cnt_ge + 3'(num >= s_data.prod[k]);
      cnt_le = cnt_le + 3'(num <= s_data.prod[k]);
    end
  end

  // Pick the sector from the axis cases and the quadrant
  always_comb begin
    same = (s_data.quad.dx_neg == s_data.quad.dy_neg);
    sect = DIR_EAST;
    data_nxt.side.pt = 1'b0;
    if (s_data.quad.dx_zero && s_data.quad.dy_zero) begin
      data_nxt.side.pt = 1'b1;
    end else if (s_data.quad.dx_zero) begin
      sect = s_data.quad.dy_neg ? DIR_SOUTH : DIR_NORTH;
    end else if (s_data.quad.dy_zero) begin
      sect = s_data.quad.dx_neg ? DIR_WEST : DIR_EAST;
    end else if (same) begin
      // quadrants I and III
      sect = 4'(cnt_ge) + (s_data.quad.dx_neg ? DIR_HALF : 4'd0);
    end else begin
      // quadrants II and IV, the latter wrapping past 15
      sect = DIR_NORTH + 4'(cnt_le) + (s_data.quad.dx_neg ? 4'd0 : DIR_HALF);
    end
    data_nxt.side.dir = sect;
    data_nxt.sum      = SUM_W'(s_data.sq_x) + SUM_W'(s_data.sq_y);
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= s_valid;
    end
  end

  // Hold the item until the root section takes it
  always_ff @(posedge clk) begin
    if (rdy && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_data  = data_r;

endmodule

[rtl/vld_sqrt.sv]
// ----------------------------------------------------------------------------
// vld_sqrt : pipelined integer square root
// One result bit per stage, most significant first: each stage tries the bit
// against the running remainder and keeps it when the remainder allows.
// ----------------------------------------------------------------------------
module vld_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  vld_pkg::vld_sum_t          s_data,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [vld_pkg::LEN_W-1:0]  m_root,
  output vld_pkg::vld_side_t         m_side
);
  import vld_pkg::*;

  logic              v_r    [LEN_W];
  logic [REM_W-1:0]  rem_r  [LEN_W];
  logic [LEN_W-1:0]  root_r [LEN_W];
  vld_side_t         side_r [LEN_W];
  logic              rdy    [LEN_W];

  assign s_ready = rdy[0];

  for (genvar k = 0; k < LEN_W; k++) begin : g_stage
    localparam int B = LEN_W - 1 - k;

    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [LEN_W-1:0]  root_in;
    vld_side_t         side_in;
    logic              rdy_out;
    logic [REM_W-1:0]  delta;
    logic              take;
    logic [REM_W-1:0]  rem_nxt;
    logic [LEN_W-1:0]  root_nxt;

    // Select the previous stage, or the section input for the first one
    if (k == 0) begin : g_first
      assign v_in    = s_valid;
      assign rem_in  = REM_W'(s_data.sum);
      assign root_in = '0;
      assign side_in = s_data.side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    if (k == LEN_W - 1) begin : g_last
      assign rdy_out = m_ready;
    end else begin : g_mid
      assign rdy_out = rdy[k+1];
    end

    assign rdy[k] = !v_r[k] || rdy_out;

    // Try this bit: (root + 2^B)^2 - root^2 = (2*root + 2^B) * 2^B
    always_comb begin
      delta    = ((REM_W'(root_in) << 1) | (REM_W'(1) << B)) << B;
      take     = (rem_in >= delta);
      rem_nxt  = take ? (rem_in - delta) : rem_in;
      root_nxt = root_in | (LEN_W'(take) << B);
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    // Load the partial root, remainder and side fields
    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign m_valid = v_r[LEN_W-1];
  assign m_root  = root_r[LEN_W-1];
  assign m_side  = side_r[LEN_W-1];

endmodule

[sim/tb_vector_length_and_direction_16_top.sv]
// ----------------------------------------------------------------------------
// tb_vector_length_and_direction_16_top : length and sector direction checks
// Drives start and end points into the block over a valid/ready channel and
// compares every result item with an independent prediction of the integer
// length, the 16-sector direction code and the zero-vector flag. Directed
// vectors cover the axes, the quadrants, the tangent boundaries and the
// wrap of quadrant IV; random vectors follow, under changing idle patterns
// on both sides.
// ----------------------------------------------------------------------------
module tb_vector_length_and_direction_16_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vld_pkg::*;

  localparam int LIMIT_NS   = 4_000_000;
  localparam int DRAIN_CYC  = 40;
  localparam int PHASE_ITEMS = 343;

  // Expected fields of one result item
  typedef struct {
    logic [LEN_W-1:0] length;
    logic [3:0]       direction;
    logic             is_point;
  } vec_result_t;

  // Prediction of length and sector, with the queue of results still owed
  class length_dir_board;
    vec_result_t owed[$];
    int          errors = 0;

    // Work out the result for one accepted item and hold it
    function void note_vector(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                              logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
      longint unsigned slope_q16[4] = '{13036, 43790, 98082, 329472};
      longint          dx;
      longint          dy;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned sum;
      longint unsigned root;
      longint unsigned cand;
      longint unsigned num;
      int              sector;
      vec_result_t     res;
      dx = longint'($signed(ex)) - longint'($signed(sx));
      dy = longint'($signed(ey)) - longint'($signed(sy));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      res.is_point  = (dx == 0) && (dy == 0);
      res.direction = DIR_EAST;
      // Digit-by-digit integer square root of the sum of squares
      sum  = ax * ax + ay * ay;
      root = 0;
      for (int b = LEN_W; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= sum) root = cand;
      end
      res.length = root[LEN_W-1:0];
      if (!res.is_point) begin
        if (dx == 0) begin
          res.direction = (dy > 0) ? DIR_NORTH : DIR_SOUTH;
        end else if (dy == 0) begin
          res.direction = (dx < 0) ? DIR_WEST : DIR_EAST;
        end else begin
          num = ay << 16;
          if ((dx > 0) == (dy > 0)) begin
            // Same signs: count thresholds reached, strict below
            sector = 0;
            foreach (slope_q16[j]) if (num >= slope_q16[j] * ax) sector++;
            if (dx < 0) sector += DIR_HALF;
          end else begin
            // Opposite signs: count from north, wrap sixteen to east
            sector = DIR_NORTH;
            foreach (slope_q16[j]) if (num <= slope_q16[j] * ax) sector++;
            if (dx > 0) sector = (sector + DIR_HALF) % 16;
          end
          res.direction = sector[3:0];
        end
      end
      owed.push_back(res);
    endfunction

    // Compare one accepted result item with the oldest one owed
    function void check_result(logic [LEN_W-1:0] length, logic [3:0] direction,
                               logic is_point);
      vec_result_t exp_res;
      if (owed.size() == 0) begin
        $error("result item with none owed: length %0d direction %0d is_point %0b",
               length, direction, is_point);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (length !== exp_res.length) begin
        $error("length: expected %0d, got %0d", exp_res.length, length);
        errors++;
      end
      if (direction !== exp_res.direction) begin
        $error("direction: expected %0d, got %0d", exp_res.direction, direction);
        errors++;
      end
      if (is_point !== exp_res.is_point) begin
        $error("is_point: expected %0b, got %0b", exp_res.is_point, is_point);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] in_start_x = '0;
  logic [COORD_W-1:0] in_start_y = '0;
  logic [COORD_W-1:0] in_end_x = '0;
  logic [COORD_W-1:0] in_end_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEN_W-1:0]   out_length;
  logic [3:0]         out_direction;
  logic               out_is_point;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  length_dir_board board = new;

  vector_length_and_direction_16_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_length   (out_length),
    .out_direction(out_direction),
    .out_is_point (out_is_point)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the receiver at random, at the current idle rate
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Check each result item; sample on the falling edge before the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_length, out_direction, out_is_point);
    end
  end

  // Offer one item after a random gap and hold it until accepted;
  // only the low coordinate bits of each argument are driven
  task automatic send_vector(input int sx, input int sy, input int ex, input int ey);
    bit taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= COORD_W'(sx);
    in_start_y <= COORD_W'(sy);
    in_end_x   <= COORD_W'(ex);
    in_end_y   <= COORD_W'(ey);
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    board.note_vector(COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey));
  endtask

  // Place a delta of given magnitude and sign at a random spot in range
  function automatic void place(input int mag, input bit neg,
                                output int s, output int e);
    int base;
    base = -32768 + int'($urandom_range(65535 - mag));
    s = neg ? base + mag : base;
    e = neg ? base : base + mag;
  endfunction

  // One random item: raw fields, near a tangent, tiny deltas or scaled deltas
  task automatic send_random_vector();
    longint unsigned slope_q16[4] = '{13036, 43790, 98082, 329472};
    int              ax_max[4] = '{65535, 65535, 43000, 13000};
    int sx;
    int sy;
    int ex;
    int ey;
    int ax;
    int ay;
    int j;
    case ($urandom_range(3))
      0: begin
        send_vector($urandom, $urandom, $urandom, $urandom);
        return;
      end
      1: begin
        j  = $urandom_range(3);
        ax = 1 + $urandom_range(ax_max[j] - 1);
        ay = int'((slope_q16[j] * ax) >> 16) + $urandom_range(2) - 1;
        if (ay < 0) ay = 0;
        if (ay > 65535) ay = 65535;
      end
      2: begin
        ax = $urandom_range(3);
        ay = $urandom_range(3);
      end
      default: begin
        ax = $urandom_range(65535) >> $urandom_range(15);
        ay = $urandom_range(65535) >> $urandom_range(15);
      end
    endcase
    place(ax, 1'($urandom_range(1)), sx, ex);
    place(ay, 1'($urandom_range(1)), sy, ey);
    send_vector(sx, sy, ex, ey);
  endtask

  // Main sequence: reset, directed items, three idle patterns, drain
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 19;
    out_idle_pct = 80;

    // Zero-length vectors
    send_vector(0, 0, 0, 0);
    send_vector(1234, -567, 1234, -567);
    // Longest diagonals in each quadrant
    send_vector(-32768, -32768, 32767, 32767);
    send_vector(32767, 32767, -32768, -32768);
    send_vector(32767, -32768, -32768, 32767);
    send_vector(-32768, 32767, 32767, -32768);
    // Axis directions
    send_vector(0, 0, 0, 32767);
    send_vector(0, 32767, 0, -32768);
    send_vector(-32768, 0, 32767, 0);
    send_vector(32767, 5, -32768, 5);
    // Slopes exactly on each tangent, one step below the first, either side of the last
    send_vector(0, 0, 16384, 3259);
    send_vector(0, 0, -16384, 3259);
    send_vector(0, 0, 16384, 3258);
    send_vector(-32768, 0, 0, 21895);
    send_vector(0, 0, -32768, -21895);
    send_vector(-32768, 16384, 0, -32657);
    send_vector(0, 0, 256, 1287);
    send_vector(0, 0, -256, -1287);
    send_vector(0, 0, 256, 1288);
    send_vector(0, 0, -256, 1286);
    // Quadrant IV wrap to east, and steep quadrant IV
    send_vector(0, 0, 100, -1);
    send_vector(0, 0, 1, -100);
    // Unit diagonals
    send_vector(0, 0, 1, 1);
    send_vector(0, 0, -1, 1);

    repeat (PHASE_ITEMS) send_random_vector();

    in_idle_pct  = 80;
    out_idle_pct = 19;
    repeat (PHASE_ITEMS) send_random_vector();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (PHASE_ITEMS) send_random_vector();

    // Drop valid and wait for every owed result, then a little longer
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
